@@ rtl/multi_policy_process_scheduler_macros.svh @@
// Assertion helpers used by the scheduler controller.
`ifndef MULTI_POLICY_PROCESS_SCHEDULER_MACROS_SVH
`define MULTI_POLICY_PROCESS_SCHEDULER_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define MPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define MPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mps_pkg.sv @@
// ----------------------------------------------------------------------------
// mps_pkg
// Types, codes and constants of the multi-policy process scheduler.
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int TABLE_SIZE_DEF = 16;
    localparam logic [16:0] Q_ONE     = 17'h10000;
    localparam logic [16:0] USAGE_MAX = 17'h1FFFF;
    localparam logic [39:0] RATIO_BOUND = 40'd10000000 << 16;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_END   = 3'd1,
        OP_PICK  = 3'd2,
        OP_TICK  = 3'd3,
        OP_REQ   = 3'd4
    } op_t;

    localparam logic [2:0] POL_ARB  = 3'd0;
    localparam logic [2:0] POL_FIFO = 3'd1;
    localparam logic [2:0] POL_LIFO = 3'd2;
    localparam logic [2:0] POL_RR   = 3'd3;
    localparam logic [2:0] POL_PS   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_DIV2,
        ST_REQ,
        ST_REQ_WAIT,
        ST_WALK,
        ST_CLEAR,
        ST_DONE,
        ST_OUT
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture input beat
        logic scan_clr;  // reset scan index and accumulators (not read by the datapath; load does this)
        logic scan_step; // visit one entry
        logic div_go;    // start divider on current entry or on the rate request
        logic tick_upd;  // write usage from divider
        logic ratio_upd; // write ratio from divider
        logic walk_step; // follow one link in end walk
        logic clr_step;  // clear one entry's usage counters
        logic finish;    // apply final update and form result
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic scan_last;
        logic div_busy;
        logic need_div;
        logic need_ratio;
        logic walk_done;
        logic clr_last;
        logic need_clear;
    } stat_t;

endpackage

@@ rtl/mps_if.sv @@
// ----------------------------------------------------------------------------
// mps_in_if / mps_out_if
// Valid/ready channels of the scheduler.
// ----------------------------------------------------------------------------
interface mps_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [15:0] process_id;
    logic [15:0] rate_numerator;
    logic [15:0] rate_denominator;
    modport source (output valid, operation, process_id, rate_numerator,
                    rate_denominator, input ready);
    modport sink (input valid, operation, process_id, rate_numerator,
                  rate_denominator, output ready);
endinterface

interface mps_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [15:0] chosen_pid;
    logic        reschedule;
    modport source (output valid, status, chosen_pid, reschedule, input ready);
    modport sink (input valid, status, chosen_pid, reschedule, output ready);
endinterface

@@ rtl/mps_div.sv @@
// ----------------------------------------------------------------------------
// mps_div
// Restoring divider, one quotient bit per cycle, 48-bit dividend.
// ----------------------------------------------------------------------------
module mps_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [47:0] quotient
);
    logic [47:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    // Load the operands on start; otherwise shift in one dividend bit and try a subtract.
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[31:0], q_reg[47]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 6'd47;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[46:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[46:0], 1'b0};
            end
            if (cnt_reg == 6'd0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;
endmodule

@@ rtl/mps_ctrl.sv @@
// ----------------------------------------------------------------------------
// mps_ctrl
// Sequencer: drives the datapath through scan, divide, walk and clear steps.
// ----------------------------------------------------------------------------
module mps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [2:0]       in_op,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output mps_pkg::cmd_t    cmd,
    input  mps_pkg::stat_t   stat
);
    import mps_pkg::*;
    `include "multi_policy_process_scheduler_macros.svh"

    state_t state_reg, state_next;
    logic [2:0] op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    op_next = in_op;
                    priority if (in_op == OP_TICK || in_op == OP_PICK)
                        state_next = ST_SCAN;
                    else if (in_op == OP_END)
                        state_next = ST_WALK;
                    else if (in_op == OP_REQ)
                        state_next = ST_REQ;
                    else
                        state_next = ST_DONE;
                end
            ST_SCAN:
                priority if (stat.scan_last)
                    state_next = ST_DONE;
                else if (op_reg == OP_TICK && stat.need_div)
                    state_next = ST_DIV;
            ST_DIV:
                if (!stat.div_busy)
                    state_next = stat.need_ratio ? ST_DIV2 : (stat.scan_last ? ST_DONE : ST_SCAN);
            ST_DIV2:
                if (!stat.div_busy)
                    state_next = stat.scan_last ? ST_DONE : ST_SCAN;
            ST_REQ:
                state_next = ST_REQ_WAIT;
            ST_REQ_WAIT:
                if (!stat.div_busy)
                    state_next = ST_DONE;
            ST_WALK:
                if (stat.walk_done)
                    state_next = ST_DONE;
            ST_DONE:
                state_next = stat.need_clear ? ST_CLEAR : ST_OUT;
            ST_CLEAR:
                if (stat.clr_last)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Issue datapath commands per state.
    always_comb
    begin
        cmd       = '0;
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                end
            ST_SCAN:
                if (!stat.scan_last)
                begin
                    if (op_reg == OP_TICK && stat.need_div)
                        cmd.div_go = 1'b1;
                    else
                        cmd.scan_step = 1'b1;
                end
            ST_DIV:
                if (!stat.div_busy)
                begin
                    cmd.tick_upd = 1'b1;
                    if (!stat.need_ratio)
                        cmd.scan_step = 1'b1;
                end
            ST_DIV2:
                if (!stat.div_busy)
                begin
                    cmd.ratio_upd = 1'b1;
                    cmd.scan_step = 1'b1;
                end
            ST_REQ:
                cmd.div_go = 1'b1;
            ST_REQ_WAIT:
                cmd = '0;
            ST_WALK:
                cmd.walk_step = 1'b1;
            ST_DONE:
                cmd.finish = 1'b1;
            ST_CLEAR:
                cmd.clr_step = 1'b1;
            ST_OUT:
                cmd = '0;
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    `MPS_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready && out_valid, 1'b0, "ready and valid overlap")
    `MPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
    `MPS_ASSERT_NEXT(a_load_leaves, clk, rst_n, in_valid && in_ready, !in_ready, "idle after accept")
endmodule

@@ rtl/mps_dp.sv @@
// ----------------------------------------------------------------------------
// mps_dp
// Process table, list pointers, scan accumulators and result register.
// ----------------------------------------------------------------------------
module mps_dp #(
    parameter int TABLE_SIZE = mps_pkg::TABLE_SIZE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [2:0]     policy,
    input  logic [2:0]     in_op,
    input  logic [15:0]    in_pid,
    input  logic [15:0]    in_m,
    input  logic [15:0]    in_n,
    input  mps_pkg::cmd_t  cmd,
    output mps_pkg::stat_t stat,
    output logic           res_status,
    output logic [15:0]    res_pid,
    output logic           res_resched
);
    import mps_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int LW = IW + 1;
    localparam logic [LW-1:0] NO_LINK = LW'(TABLE_SIZE);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SIZE - 1);

    // Entry arrays (read at the scan index and at the list, walk and pick pointers).
    logic [TABLE_SIZE-1:0] valid_reg;
    logic [15:0] pid_reg   [TABLE_SIZE];
    logic [LW-1:0] link_reg [TABLE_SIZE];
    logic [31:0] run_reg   [TABLE_SIZE];
    logic [31:0] alive_reg [TABLE_SIZE];
    logic [16:0] usage_reg [TABLE_SIZE];
    logic [16:0] share_reg [TABLE_SIZE];
    logic [39:0] ratio_reg [TABLE_SIZE];

    logic [IW-1:0] head_reg, tail_reg, rr_run_reg;
    logic [LW-1:0] rr_up_reg;
    logic [16:0]   total_reg;

    logic [2:0]  op_reg;
    logic [15:0] pid_in_reg, m_reg, n_reg;

    // Scan and walk state.
    logic [IW-1:0] idx_reg;
    logic          last_reg;
    logic [LW-1:0] bfree_reg, bres_reg, found_reg, first_free_reg;
    logic [16:0]   minuse_reg;
    logic [39:0]   minratio_reg;
    logic [IW-1:0] prev_reg;
    logic [LW-1:0] walk_reg;
    logic [IW:0]   steps_reg;
    logic          wdone_reg, wfound_reg;

    // Divider.
    logic        div_go, div_busy;
    logic [47:0] div_a, div_q;
    logic [31:0] div_b;
    logic        div_sel_reg;

    mps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    logic [31:0] alive_inc;
    logic [16:0] use_sat;
    logic        idx_v;
    assign idx_v     = valid_reg[idx_reg];
    assign alive_inc = (alive_reg[idx_reg] != COUNT_MAX) ? alive_reg[idx_reg] + 32'd1
                                                         : alive_reg[idx_reg];
    assign use_sat   = (div_q > {31'd0, USAGE_MAX}) ? USAGE_MAX : div_q[16:0];

    // Divider operands: rate request, usage, then ratio from the usage just written.
    always_comb
    begin
        div_go = cmd.div_go || (cmd.tick_upd && share_reg[idx_reg] != 17'd0);
        if (cmd.div_go && op_reg == OP_REQ)
        begin
            div_a = {16'd0, m_reg, 16'd0};
            div_b = {16'd0, n_reg};
        end
        else if (cmd.div_go)
        begin
            div_a = {run_reg[idx_reg], 16'd0};
            div_b = alive_inc;
        end
        else
        begin
            div_a = {15'd0, use_sat, 16'd0};
            div_b = {15'd0, share_reg[idx_reg]};
        end
    end

    logic head_live;
    assign head_live = valid_reg[head_reg];

    // Request evaluation (combinational on found entry).
    logic [31:0] req_share;
    logic [16:0] req_sum;
    logic [IW-1:0] fidx;
    logic [LW-1:0] wl;
    assign fidx    = found_reg[IW-1:0];
    assign wl      = link_reg[walk_reg[IW-1:0]];
    assign req_sum = (total_reg >= share_reg[fidx]) ? total_reg - share_reg[fidx] : 17'd0;

    // m * 65536 / n comes from the shared divider, run once before finish.
    assign req_share = div_q[31:0];

    function automatic logic [IW-1:0] fidx_free();
        return first_free_reg[IW-1:0];
    endfunction

    function automatic logic req_ok();
        return (found_reg != NO_LINK) && (m_reg != 16'd0) && (n_reg != 16'd0) &&
               (m_reg <= n_reg) && ({1'b0, req_sum} + {1'b0, req_share[16:0]} <=
               {1'b0, Q_ONE});
    endfunction

    // Removal behind the head, or a granted request, clears all usage.
    logic end_inner;
    assign end_inner = head_live && pid_reg[head_reg] != pid_in_reg && wfound_reg;

    assign stat.scan_last  = last_reg;
    assign stat.div_busy   = div_busy;
    assign stat.need_div   = idx_v;
    assign stat.need_ratio = (share_reg[idx_reg] != 17'd0) && !div_sel_reg;
    assign stat.walk_done  = wdone_reg;
    assign stat.clr_last   = last_reg;
    assign stat.need_clear = (op_reg == OP_END && end_inner) || (op_reg == OP_REQ && req_ok());

    logic [LW-1:0] pick_idx;
    logic          ps_res;
    assign ps_res = (bres_reg != NO_LINK) && (minratio_reg < {23'd0, Q_ONE} ||
                    bfree_reg == NO_LINK);

    logic [IW-1:0] rr_sel;
    logic          rr_ok;
    assign rr_sel = (rr_up_reg < NO_LINK && valid_reg[rr_up_reg[IW-1:0]]) ?
                    rr_up_reg[IW-1:0] : head_reg;
    assign rr_ok  = valid_reg[rr_sel];

    assign pick_idx = ps_res ? bres_reg : bfree_reg;

    // Start and request need the lowest free entry and the first pid match;
    // resolve them with a find-first over the valid bits at load.
    logic [LW-1:0] ff_free, ff_match;
    always_comb
    begin
        ff_free  = NO_LINK;
        ff_match = NO_LINK;
        for (int i = TABLE_SIZE - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
                ff_free = LW'(i);
            if (valid_reg[i] && pid_reg[i] == in_pid)
                ff_match = LW'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            rr_run_reg <= '0;
            rr_up_reg  <= '0;
            total_reg  <= '0;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                link_reg[i]  <= NO_LINK;
                run_reg[i]   <= '0;
                alive_reg[i] <= '0;
                usage_reg[i] <= '0;
                share_reg[i] <= '0;
                ratio_reg[i] <= '0;
            end
        end
        else
        begin
            // Tick update of one entry.
            if (cmd.tick_upd)
            begin
                alive_reg[idx_reg] <= alive_inc;
                usage_reg[idx_reg] <= use_sat;
            end
            if (cmd.ratio_upd)
                ratio_reg[idx_reg] <= div_q[39:0];
            if (cmd.clr_step)
            begin
                run_reg[idx_reg]   <= '0;
                alive_reg[idx_reg] <= '0;
                usage_reg[idx_reg] <= '0;
            end
            // End walk: unlink at the matching entry.
            if (cmd.walk_step && !wdone_reg && walk_reg < NO_LINK &&
                valid_reg[walk_reg[IW-1:0]] && pid_reg[walk_reg[IW-1:0]] == pid_in_reg &&
                steps_reg != '0)
            begin
                valid_reg[walk_reg[IW-1:0]] <= 1'b0;
                link_reg[prev_reg] <= wl;
                if (walk_reg[IW-1:0] == tail_reg)
                    tail_reg <= prev_reg;
                total_reg <= (total_reg >= share_reg[walk_reg[IW-1:0]]) ?
                             total_reg - share_reg[walk_reg[IW-1:0]] : 17'd0;
            end
            if (cmd.finish)
            begin
                unique case (op_reg)
                    OP_START:
                        if (first_free_reg != NO_LINK)
                        begin
                            valid_reg[fidx_free()]  <= 1'b1;
                            link_reg[fidx_free()]   <= NO_LINK;
                            run_reg[fidx_free()]    <= '0;
                            alive_reg[fidx_free()]  <= '0;
                            usage_reg[fidx_free()]  <= '0;
                            share_reg[fidx_free()]  <= '0;
                            ratio_reg[fidx_free()]  <= '0;
                            if (!head_live)
                                head_reg <= fidx_free();
                            else
                                link_reg[tail_reg] <= first_free_reg;
                            tail_reg <= fidx_free();
                        end
                    OP_END:
                        if (head_live && pid_reg[head_reg] == pid_in_reg)
                        begin
                            valid_reg[head_reg] <= 1'b0;
                            head_reg <= (link_reg[head_reg] < NO_LINK) ?
                                        link_reg[head_reg][IW-1:0] : '0;
                            total_reg <= (total_reg >= share_reg[head_reg]) ?
                                         total_reg - share_reg[head_reg] : 17'd0;
                        end
                    OP_PICK:
                        if (policy == POL_RR && rr_ok)
                        begin
                            rr_run_reg <= rr_sel;
                            rr_up_reg  <= link_reg[rr_sel];
                        end
                        else if (policy == POL_RR)
                            rr_up_reg <= {{(LW-IW){1'b0}}, rr_sel};
                        else if (policy == POL_PS && pick_idx != NO_LINK &&
                                 run_reg[pick_idx[IW-1:0]] != COUNT_MAX)
                            run_reg[pick_idx[IW-1:0]] <= run_reg[pick_idx[IW-1:0]] + 32'd1;
                    OP_REQ:
                        if (req_ok())
                        begin
                            total_reg <= req_sum + req_share[16:0];
                            share_reg[fidx] <= req_share[16:0];
                        end
                    default:
                        total_reg <= total_reg;
                endcase
            end
        end
    end

    // Pid writes, input capture, scan and result.
    always_ff @(posedge clk)
    begin
        if (cmd.finish && op_reg == OP_START && first_free_reg != NO_LINK)
            pid_reg[first_free_reg[IW-1:0]] <= pid_in_reg;
    end

    logic [15:0] pick_pid;
    always_comb
    begin
        pick_pid = 16'd0;
        unique case (policy)
            POL_ARB:
                if (first_free_reg != NO_LINK)
                    pick_pid = pid_reg[first_free_reg[IW-1:0]];
            POL_FIFO:
                if (head_live)
                    pick_pid = pid_reg[head_reg];
            POL_LIFO:
                if (head_live)
                    pick_pid = pid_reg[tail_reg];
            POL_RR:
                if (rr_ok)
                    pick_pid = pid_reg[rr_sel];
            POL_PS:
                if (pick_idx != NO_LINK)
                    pick_pid = pid_reg[pick_idx[IW-1:0]];
            default:
                pick_pid = 16'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            last_reg <= 1'b0;
            wdone_reg <= 1'b0;
            div_sel_reg <= 1'b0;
            res_status <= 1'b0;
            res_pid <= '0;
            res_resched <= 1'b0;
            op_reg <= '0;
            pid_in_reg <= '0;
            m_reg <= '0;
            n_reg <= '0;
            bfree_reg <= NO_LINK;
            bres_reg <= NO_LINK;
            found_reg <= NO_LINK;
            first_free_reg <= NO_LINK;
            minuse_reg <= 17'h1FFFF;
            minratio_reg <= RATIO_BOUND;
            prev_reg <= '0;
            walk_reg <= '0;
            steps_reg <= '0;
            wfound_reg <= 1'b0;
        end
        else
        begin
            // Capture the beat; start takes the lowest free entry, pick scans
            // for the lowest valid one.
            if (cmd.load)
            begin
                op_reg        <= in_op;
                pid_in_reg    <= in_pid;
                m_reg         <= in_m;
                n_reg         <= in_n;
                idx_reg       <= '0;
                last_reg      <= 1'b0;
                bfree_reg     <= NO_LINK;
                bres_reg      <= NO_LINK;
                found_reg     <= ff_match;
                first_free_reg <= (in_op == OP_START) ? ff_free : NO_LINK;
                minuse_reg    <= 17'h1FFFF;
                minratio_reg  <= RATIO_BOUND;
                prev_reg      <= head_reg;
                walk_reg      <= '0;
                steps_reg     <= '0;
                wdone_reg     <= 1'b0;
                wfound_reg    <= 1'b0;
                div_sel_reg   <= 1'b0;
            end
            if (cmd.div_go)
                div_sel_reg <= 1'b0;
            if (cmd.tick_upd && share_reg[idx_reg] != 17'd0)
                div_sel_reg <= 1'b1;
            // Visit one entry in index order.
            if (cmd.scan_step)
            begin
                if (valid_reg[idx_reg])
                begin
                    if (first_free_reg == NO_LINK)
                        first_free_reg <= {1'b0, idx_reg};
                    if (share_reg[idx_reg] == 17'd0)
                    begin
                        if (usage_reg[idx_reg] < minuse_reg || minuse_reg == 17'h1FFFF &&
                            bfree_reg == NO_LINK && usage_reg[idx_reg] != 17'h1FFFF)
                        begin
                            minuse_reg <= usage_reg[idx_reg];
                            bfree_reg  <= {1'b0, idx_reg};
                        end
                        else if (bfree_reg == NO_LINK && usage_reg[idx_reg] == 17'h1FFFF)
                        begin
                            bfree_reg <= {1'b0, idx_reg};
                        end
                    end
                    else if (ratio_reg[idx_reg] < minratio_reg)
                    begin
                        minratio_reg <= ratio_reg[idx_reg];
                        bres_reg     <= {1'b0, idx_reg};
                    end
                end
                div_sel_reg <= 1'b0;
                if (idx_reg == LAST_IDX)
                    last_reg <= 1'b1;
                else
                    idx_reg <= idx_reg + 1'b1;
            end
            // Follow one link of the end walk.
            if (cmd.walk_step && !wdone_reg)
            begin
                if (steps_reg == '0)
                begin
                    walk_reg  <= link_reg[head_reg];
                    steps_reg <= steps_reg + 1'b1;
                    if (!head_live || pid_reg[head_reg] == pid_in_reg)
                        wdone_reg <= 1'b1;
                end
                else if (walk_reg < NO_LINK && valid_reg[walk_reg[IW-1:0]] &&
                         steps_reg <= (IW+1)'(TABLE_SIZE))
                begin
                    if (pid_reg[walk_reg[IW-1:0]] == pid_in_reg)
                    begin
                        wfound_reg <= 1'b1;
                        wdone_reg  <= 1'b1;
                    end
                    else
                    begin
                        prev_reg  <= walk_reg[IW-1:0];
                        walk_reg  <= wl;
                        steps_reg <= steps_reg + 1'b1;
                    end
                end
                else
                    wdone_reg <= 1'b1;
            end
            if (cmd.clr_step)
            begin
                if (idx_reg == LAST_IDX)
                    last_reg <= 1'b1;
                else
                    idx_reg <= idx_reg + 1'b1;
            end
            // Form the result beat.
            if (cmd.finish)
            begin
                res_pid     <= 16'd0;
                res_resched <= 1'b0;
                res_status  <= 1'b0;
                idx_reg     <= '0;
                last_reg    <= 1'b0;
                unique case (op_reg)
                    OP_START:
                    begin
                        res_status  <= (first_free_reg == NO_LINK);
                        res_resched <= (first_free_reg != NO_LINK) && policy == POL_LIFO &&
                                       head_live;
                    end
                    OP_END:
                        res_status <= !(head_live && (pid_reg[head_reg] == pid_in_reg ||
                                       wfound_reg));
                    OP_PICK:
                        res_pid <= pick_pid;
                    OP_TICK:
                        res_resched <= (policy == POL_RR || policy == POL_PS);
                    OP_REQ:
                        res_status <= !req_ok();
                    default:
                        res_status <= 1'b1;
                endcase
            end
        end
    end
endmodule

@@ rtl/multi_policy_process_scheduler.sv @@
// Operation: start and unknown ops form the result beat without a scan; a rate request
// runs one divide; pick scans the table; end walks the list, one link per cycle; a tick
// runs a divide per valid entry (a second one with a share) and steps over free entries;
// a usage clear adds a pass over the table.
// Throughput: one item at a time, the next accepted after the result is taken.
// Reset clears the table, list pointers and shares; policy resets to fifo.
// ----------------------------------------------------------------------------
// multi_policy_process_scheduler
// Process table scheduler with selectable policy and proportional share.
// ----------------------------------------------------------------------------
module multi_policy_process_scheduler #(
    parameter int TABLE_SIZE = mps_pkg::TABLE_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    mps_in_if.sink      in_ch,
    mps_out_if.source   out_ch
);
    import mps_pkg::*;

    logic [2:0] policy_reg;
    cmd_t  cmd;
    stat_t stat;

    // Hold the policy register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            policy_reg <= POL_FIFO;
        else if (cfg_we)
            policy_reg <= cfg_wdata;
    end

    mps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_op     (in_ch.operation),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    mps_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .policy      (policy_reg),
        .in_op       (in_ch.operation),
        .in_pid      (in_ch.process_id),
        .in_m        (in_ch.rate_numerator),
        .in_n        (in_ch.rate_denominator),
        .cmd         (cmd),
        .stat        (stat),
        .res_status  (out_ch.status),
        .res_pid     (out_ch.chosen_pid),
        .res_resched (out_ch.reschedule)
    );
endmodule

@@ tb/sv/multi_policy_process_scheduler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_policy_process_scheduler_tb
// Drives start, end, pick, tick and rate request events into the scheduler
// under every policy setting. An event-level predictor of the process table
// computes each expected result beat, and the monitor compares every field.
// ----------------------------------------------------------------------------
module multi_policy_process_scheduler_tb;
    import mps_pkg::*;

    localparam int          SLOTS         = 16;
    localparam logic [4:0]  NO_SUCC       = 5'd16;
    localparam logic [2:0]  OP_UNDEF_LO   = 3'd5;
    localparam logic [2:0]  OP_UNDEF_HI   = 3'd7;
    localparam logic [2:0]  POL_UNDEF_LO  = 3'd5;
    localparam logic [2:0]  POL_UNDEF_HI  = 3'd7;
    localparam int          CYCLE_LIMIT   = 5000000;
    localparam int          RANDOM_ITEMS  = 900;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] pid;
        logic [15:0] m;
        logic [15:0] n;
    } event_t;

    typedef struct packed {
        logic        status;
        logic [15:0] chosen;
        logic        resched;
    } outcome_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_wdata;

    mps_in_if  in_ch ();
    mps_out_if out_ch ();

    multi_policy_process_scheduler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Scheduler state as predicted
    bit          slot_valid [SLOTS];
    bit [15:0]   slot_pid   [SLOTS];
    bit [4:0]    slot_link  [SLOTS];
    bit [31:0]   slot_run   [SLOTS];
    bit [31:0]   slot_alive [SLOTS];
    bit [16:0]   slot_usage [SLOTS];
    bit [16:0]   slot_share [SLOTS];
    bit [39:0]   slot_ratio [SLOTS];
    bit [3:0]    head_slot;
    bit [3:0]    tail_slot;
    bit [3:0]    rr_current;
    bit [4:0]    rr_next;
    bit [16:0]   share_sum;
    bit [2:0]    sched_policy;

    event_t      pending_events [$];
    outcome_t    expected_outcomes [$];
    event_t      in_flight;
    int          errors;
    int          outcomes_checked;
    int          events_sent;
    int          cycles;
    bit [15:0]   pid_pool [8];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit slot_live(bit [4:0] i);
        return i < SLOTS && slot_valid[i[3:0]];
    endfunction

    function automatic void clear_all_usage();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_run[i]   = '0;
            slot_alive[i] = '0;
            slot_usage[i] = '0;
        end
    endfunction

    function automatic void release_share(int i);
        share_sum = (share_sum >= slot_share[i]) ? share_sum - slot_share[i] : '0;
    endfunction

    function automatic void reset_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_pid[i]   = '0;
            slot_link[i]  = NO_SUCC;
            slot_share[i] = '0;
            slot_ratio[i] = '0;
        end
        clear_all_usage();
        head_slot    = '0;
        tail_slot    = '0;
        rr_current   = '0;
        rr_next      = '0;
        share_sum    = '0;
        sched_policy = POL_FIFO;
    endfunction

    function automatic outcome_t schedule_event(event_t ev);
        outcome_t res;
        bit       was_empty;
        int       free_slot;
        int       found;
        bit [4:0] walk;
        bit [4:0] prev;
        bit [4:0] best_res;
        bit [4:0] best_free;
        bit [17:0] min_use;
        bit [39:0] min_ratio;
        bit [47:0] quot;
        int        new_share;
        int        rest;
        res = '0;
        case (ev.op)
            OP_START:
            begin
                was_empty = !slot_live({1'b0, head_slot});
                free_slot = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!slot_valid[i])
                        free_slot = i;
                if (free_slot < 0)
                    res.status = 1'b1;
                else
                begin
                    slot_valid[free_slot] = 1'b1;
                    slot_pid[free_slot]   = ev.pid;
                    slot_link[free_slot]  = NO_SUCC;
                    slot_run[free_slot]   = '0;
                    slot_alive[free_slot] = '0;
                    slot_usage[free_slot] = '0;
                    slot_share[free_slot] = '0;
                    slot_ratio[free_slot] = '0;
                    if (was_empty)
                        head_slot = free_slot[3:0];
                    else
                        slot_link[tail_slot] = free_slot[4:0];
                    tail_slot = free_slot[3:0];
                    res.resched = (sched_policy == POL_LIFO) && !was_empty;
                end
            end
            OP_END:
            begin
                res.status = 1'b1;
                if (slot_live({1'b0, head_slot}))
                begin
                    if (slot_pid[head_slot] == ev.pid)
                    begin
                        found = head_slot;
                        slot_valid[found] = 1'b0;
                        head_slot = (slot_link[found] < SLOTS) ? slot_link[found][3:0] : '0;
                        release_share(found);
                        res.status = 1'b0;
                    end
                    else
                    begin
                        prev = {1'b0, head_slot};
                        walk = slot_link[head_slot];
                        for (int s = 0; s < SLOTS && slot_live(walk); s++)
                        begin
                            if (slot_pid[walk[3:0]] == ev.pid)
                            begin
                                slot_valid[walk[3:0]] = 1'b0;
                                slot_link[prev[3:0]] = slot_link[walk[3:0]];
                                if (walk[3:0] == tail_slot)
                                    tail_slot = prev[3:0];
                                release_share(walk[3:0]);
                                clear_all_usage();
                                res.status = 1'b0;
                                break;
                            end
                            prev = walk;
                            walk = slot_link[walk[3:0]];
                        end
                    end
                end
            end
            OP_PICK:
            begin
                case (sched_policy)
                    POL_ARB:
                    begin
                        for (int i = SLOTS - 1; i >= 0; i--)
                            if (slot_valid[i])
                                res.chosen = slot_pid[i];
                    end
                    POL_FIFO:
                        if (slot_live({1'b0, head_slot}))
                            res.chosen = slot_pid[head_slot];
                    POL_LIFO:
                        if (slot_live({1'b0, head_slot}))
                            res.chosen = slot_pid[tail_slot];
                    POL_RR:
                    begin
                        if (!slot_live(rr_next))
                            rr_next = {1'b0, head_slot};
                        if (slot_live(rr_next))
                        begin
                            rr_current  = rr_next[3:0];
                            rr_next     = slot_link[rr_current];
                            res.chosen  = slot_pid[rr_current];
                        end
                    end
                    POL_PS:
                    begin
                        best_res  = NO_SUCC;
                        best_free = NO_SUCC;
                        min_use   = 18'h20000;
                        min_ratio = RATIO_BOUND;
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (!slot_valid[i])
                                continue;
                            if (slot_share[i] == 0)
                            begin
                                if ({1'b0, slot_usage[i]} < min_use)
                                begin
                                    min_use   = {1'b0, slot_usage[i]};
                                    best_free = i[4:0];
                                end
                            end
                            else if (slot_ratio[i] < min_ratio)
                            begin
                                min_ratio = slot_ratio[i];
                                best_res  = i[4:0];
                            end
                        end
                        found = -1;
                        if (best_res != NO_SUCC && (min_ratio < 40'(Q_ONE) || best_free == NO_SUCC))
                            found = best_res;
                        else if (best_free != NO_SUCC)
                            found = best_free;
                        if (found >= 0)
                        begin
                            if (slot_run[found] != COUNT_MAX)
                                slot_run[found]++;
                            res.chosen = slot_pid[found];
                        end
                    end
                    default:
                        res.chosen = '0;
                endcase
            end
            OP_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!slot_valid[i])
                        continue;
                    if (slot_alive[i] != COUNT_MAX)
                        slot_alive[i]++;
                    quot = {slot_run[i], 16'h0} / {16'h0, slot_alive[i]};
                    slot_usage[i] = (quot > 48'(USAGE_MAX)) ? USAGE_MAX : quot[16:0];
                    if (slot_share[i] != 0)
                        slot_ratio[i] = {7'h0, slot_usage[i], 16'h0} / {23'h0, slot_share[i]};
                end
                res.resched = (sched_policy == POL_RR) || (sched_policy == POL_PS);
            end
            OP_REQ:
            begin
                found = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (slot_valid[i] && slot_pid[i] == ev.pid)
                        found = i;
                if (found < 0 || ev.m == 0 || ev.n == 0 || ev.m > ev.n)
                    res.status = 1'b1;
                else
                begin
                    new_share = int'({ev.m, 16'h0} / {16'h0, ev.n});
                    rest = (share_sum >= slot_share[found]) ?
                           int'(share_sum) - int'(slot_share[found]) : 0;
                    if (rest + new_share > int'(Q_ONE))
                        res.status = 1'b1;
                    else
                    begin
                        share_sum         = 17'(rest + new_share);
                        slot_share[found] = 17'(new_share);
                        clear_all_usage();
                    end
                end
            end
            default:
                res.status = 1'b1;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = '0;
        in_ch.process_id = '0;
        in_ch.rate_numerator = '0;
        in_ch.rate_denominator = '0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: bursts with random gaps, predict on each accepted beat
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            burst_left = 4;
            gap_left   = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_outcomes.push_back(schedule_event(in_flight));
                events_sent++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_events.size() > 0)
                begin
                    in_flight = pending_events.pop_front();
                    in_ch.valid            <= 1'b1;
                    in_ch.operation        <= in_flight.op;
                    in_ch.process_id       <= in_flight.pid;
                    in_ch.rate_numerator   <= in_flight.m;
                    in_ch.rate_denominator <= in_flight.n;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall patterns plus long hold-offs
    // ------------------------------------------------------------------
    int rx_cycle;
    int rx_hold;
    int rx_mode;
    int rx_mode_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_cycle     = 0;
            rx_hold      = 0;
            rx_mode      = 0;
            rx_mode_left = 0;
        end
        else
        begin
            rx_cycle++;
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ch.ready <= 1'b0;
            end
            else if (rx_cycle == 3000 || rx_cycle == 60000)
            begin
                rx_hold = 500;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(20, 200);
                end
                else
                    rx_mode_left--;
                case (rx_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: out_ch.ready <= ($urandom_range(0, 1) == 0);
                    default: out_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_outcomes.size() == 0)
                report_mismatch("unexpected result beat, status", out_ch.status, 0);
            else
            begin
                want = expected_outcomes.pop_front();
                outcomes_checked++;
                if (out_ch.status !== want.status)
                    report_mismatch("status", out_ch.status, want.status);
                if (out_ch.chosen_pid !== want.chosen)
                    report_mismatch("chosen_pid", out_ch.chosen_pid, want.chosen);
                if (out_ch.reschedule !== want.resched)
                    report_mismatch("reschedule", out_ch.reschedule, want.resched);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_event(logic [2:0] op, logic [15:0] pid, logic [15:0] m,
                             logic [15:0] n);
        event_t ev;
        ev.op  = op;
        ev.pid = pid;
        ev.m   = m;
        ev.n   = n;
        pending_events.push_back(ev);
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_events.size() != 0 || in_ch.valid || expected_outcomes.size() != 0);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_policy(logic [2:0] p);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sched_policy = p;
        @(negedge clk);
    endtask

    task automatic add_random_events(int count);
        logic [15:0] pid;
        logic [15:0] m;
        logic [15:0] n;
        int          pick;
        for (int k = 0; k < count; k++)
        begin
            pid  = ($urandom_range(0, 9) < 7) ? pid_pool[$urandom_range(0, 7)] : 16'($urandom);
            m    = 16'($urandom);
            n    = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 24)
                add_event(OP_START, pid, m, n);
            else if (pick < 44)
                add_event(OP_END, pid, m, n);
            else if (pick < 68)
                add_event(OP_PICK, pid, m, n);
            else if (pick < 80)
                add_event(OP_TICK, pid, m, n);
            else if (pick < 97)
            begin
                // Mostly small, fitting fractions; sometimes raw noise
                if ($urandom_range(0, 9) != 0)
                begin
                    n = 16'($urandom_range(1, 65535));
                    m = 16'($urandom_range(1, (n / 4) + 1));
                    if (m > n)
                        m = n;
                end
                add_event(OP_REQ, pid, m, n);
            end
            else
                add_event(3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)), pid, m, n);
        end
    endtask

    logic [2:0] phase_policy [10];

    initial
    begin
        errors = 0;
        outcomes_checked = 0;
        events_sent = 0;
        cycles = 0;
        reset_table();
        pid_pool[0] = 16'h0000;
        pid_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++)
            pid_pool[i] = 16'($urandom);
        phase_policy = '{POL_ARB, POL_FIFO, POL_LIFO, POL_RR, POL_PS, POL_UNDEF_LO,
                         3'd6, POL_UNDEF_HI, POL_PS, POL_RR};
        @(posedge rst_n);
        @(negedge clk);

        // Directed: empty table, fill to full, rate edge cases, removals
        add_event(OP_PICK, 16'd0, 16'd0, 16'd0);
        add_event(OP_END, 16'd5, 16'd0, 16'd0);
        add_event(OP_TICK, 16'd0, 16'd0, 16'd0);
        add_event(OP_REQ, 16'd9, 16'd1, 16'd2);
        add_event(OP_START, 16'h0000, 16'd0, 16'd0);
        add_event(OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 2; i < 17; i++)
            add_event(OP_START, 16'(i * 3), 16'd0, 16'd0);
        add_event(OP_REQ, 16'hFFFF, 16'd0, 16'd5);
        add_event(OP_REQ, 16'hFFFF, 16'd5, 16'd0);
        add_event(OP_REQ, 16'hFFFF, 16'd7, 16'd3);
        add_event(OP_REQ, 16'hFFFF, 16'd1, 16'd2);
        add_event(OP_REQ, 16'h0000, 16'd3, 16'd4);
        add_event(OP_REQ, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_event(OP_REQ, 16'hFFFF, 16'd1, 16'd4);
        add_event(OP_PICK, 16'd0, 16'd0, 16'd0);
        add_event(OP_TICK, 16'd0, 16'd0, 16'd0);
        add_event(OP_END, 16'd9, 16'd0, 16'd0);
        add_event(OP_END, 16'h0000, 16'd0, 16'd0);
        add_event(OP_END, 16'd1234, 16'd0, 16'd0);
        add_event(OP_UNDEF_LO, 16'd0, 16'd0, 16'd0);
        add_event(OP_UNDEF_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        wait_quiet();

        // Random phases, one per entry of phase_policy (PS and RR twice)
        foreach (phase_policy[p])
        begin
            write_policy(phase_policy[p]);
            add_random_events(RANDOM_ITEMS / 10);
            wait_quiet();
        end

        repeat (2500) @(negedge clk);
        $display("covered %0d events and %0d result beats over %0d policy settings",
                 events_sent, outcomes_checked, $size(phase_policy));
        $display("mismatches: %0d, predictions left over: %0d", errors,
                 expected_outcomes.size());
        if (errors == 0 && expected_outcomes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mps_pkg.sv
rtl/mps_if.sv
rtl/mps_div.sv
rtl/mps_ctrl.sv
rtl/mps_dp.sv
rtl/multi_policy_process_scheduler.sv
tb/sv/multi_policy_process_scheduler_tb.sv
